// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk; QSR_ASSERT is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check outside reset
`define QSR_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// check at every edge, reset included
`define QSR_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define QSR_ASSERT(name, prop)
`define QSR_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== hdl/qsr_pkg.sv =====
// ----------------------------------------------------------------------------
// qsr_pkg
// Widths, status codes and payload types of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none
package qsr_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int ROOT_WIDTH = 32;

    // discriminant, signed, and the unsigned square root work width
    localparam int DISC_W = 2 * COEF_WIDTH + 3;
    localparam int RAD_W  = DISC_W;
    localparam int SQ_W   = COEF_WIDTH + 1;
    // numerator / denominator magnitudes and the shifted dividend
    localparam int NUM_W  = COEF_WIDTH + 2;
    localparam int DIVD_W = NUM_W + 2 * FRAC_BITS;
    localparam int EXT_W  = (DIVD_W >= ROOT_WIDTH) ? DIVD_W + 1 : ROOT_WIDTH + 1;

    localparam logic [1:0] ST_REAL    = 2'd0;
    localparam logic [1:0] ST_COMPLEX = 2'd1;
    localparam logic [1:0] ST_A_ZERO  = 2'd2;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
    } eq_t;

    typedef struct packed {
        logic signed [ROOT_WIDTH-1:0] root;
        logic [1:0]                   status;
        logic                         saturated;
    } sol_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [COEF_WIDTH-1:0] b;
        logic [1:0]                   status;
    } sq_side_t;

    typedef struct packed {
        logic       neg;
        logic [1:0] status;
    } div_side_t;

endpackage
`default_nettype wire

// ===== hdl/qsr_isqrt.sv =====
// ----------------------------------------------------------------------------
// qsr_isqrt
// Pipelined integer square root, one result bit per stage, rounded down.
// ----------------------------------------------------------------------------
`default_nettype none
module qsr_isqrt
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_vld,
    input  wire logic [qsr_pkg::RAD_W-1:0] rad,
    input  wire qsr_pkg::sq_side_t        side_in,
    output logic                          out_vld,
    output logic [qsr_pkg::SQ_W-1:0]      sq_root,
    output qsr_pkg::sq_side_t             side_out
);
    import qsr_pkg::*;

    logic [SQ_W-1:0]  vld_reg;
    logic [RAD_W-1:0] rem_reg [SQ_W];
    logic [SQ_W-1:0]  q_reg   [SQ_W];
    sq_side_t         side_reg [SQ_W];

    for (genvar k = 0; k < SQ_W; k++) begin : g_stage
        localparam int BIT = SQ_W - 1 - k;
        logic             vld_in;
        logic [RAD_W-1:0] rem_in;
        logic [SQ_W-1:0]  q_in;
        sq_side_t         side_in_k;
        logic [RAD_W-1:0] trial;
        logic             ge;
        logic [RAD_W-1:0] rem_next;
        logic [SQ_W-1:0]  q_next;

        if (k == 0) begin : g_first
            assign vld_in    = in_vld;
            assign rem_in    = rad;
            assign q_in      = '0;
            assign side_in_k = side_in;
        end
        else begin : g_rest
            assign vld_in    = vld_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign q_in      = q_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        // (q + 2^i)^2 - q^2 = q*2^(i+1) + 2^(2i)
        assign trial    = (RAD_W'(q_in) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));
        assign ge       = (rem_in >= trial);
        assign rem_next = ge ? rem_in - trial : rem_in;
        assign q_next   = ge ? (q_in | (SQ_W'(1) << BIT)) : q_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_in_k;
            end
        end
    end

    assign out_vld  = vld_reg[SQ_W-1];
    assign sq_root  = q_reg[SQ_W-1];
    assign side_out = side_reg[SQ_W-1];

endmodule
`default_nettype wire

// ===== hdl/qsr_div.sv =====
// ----------------------------------------------------------------------------
// qsr_div
// Pipelined restoring divider of magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module qsr_div
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_vld,
    input  wire logic [qsr_pkg::DIVD_W-1:0] dividend,
    input  wire logic [qsr_pkg::NUM_W-1:0]  divisor,
    input  wire qsr_pkg::div_side_t        side_in,
    output logic                           out_vld,
    output logic [qsr_pkg::DIVD_W-1:0]     quotient,
    output qsr_pkg::div_side_t             side_out
);
    import qsr_pkg::*;

    logic [DIVD_W-1:0] vld_reg;
    logic [NUM_W-1:0]  rem_reg  [DIVD_W];
    logic [DIVD_W-1:0] nq_reg   [DIVD_W];
    logic [NUM_W-1:0]  dsr_reg  [DIVD_W];
    div_side_t         side_reg [DIVD_W];

    for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
        logic              vld_in;
        logic [NUM_W-1:0]  rem_in;
        logic [DIVD_W-1:0] nq_in;
        logic [NUM_W-1:0]  dsr_in;
        div_side_t         side_in_k;
        logic [NUM_W:0]    part;
        logic [NUM_W:0]    diff;
        logic              ge;
        logic [NUM_W-1:0]  rem_next;
        logic [DIVD_W-1:0] nq_next;

        if (k == 0) begin : g_first
            assign vld_in    = in_vld;
            assign rem_in    = '0;
            assign nq_in     = dividend;
            assign dsr_in    = divisor;
            assign side_in_k = side_in;
        end
        else begin : g_rest
            assign vld_in    = vld_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign nq_in     = nq_reg[k-1];
            assign dsr_in    = dsr_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        // shift the next dividend bit in; quotient bits fill from the bottom
        assign part     = {rem_in, nq_in[DIVD_W-1]};
        assign diff     = part - {1'b0, dsr_in};
        assign ge       = (part >= {1'b0, dsr_in});
        assign rem_next = ge ? diff[NUM_W-1:0] : part[NUM_W-1:0];
        assign nq_next  = {nq_in[DIVD_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                nq_reg[k]   <= nq_next;
                dsr_reg[k]  <= dsr_in;
                side_reg[k] <= side_in_k;
            end
        end
    end

    assign out_vld  = vld_reg[DIVD_W-1];
    assign quotient = nq_reg[DIVD_W-1];
    assign side_out = side_reg[DIVD_W-1];

endmodule
`default_nettype wire

// ===== hdl/quadratic_smaller_root.sv =====
// ----------------------------------------------------------------------------
// quadratic_smaller_root
// Root (-b - isqrt(b*b - 4ac)) / (2a) of Q8.8 coefficients (the smaller real root
// for positive a), returned in Q16.16, saturated, with complex and a-zero status.
//
//   channel   signals                          payload
//   eq        eq_valid, eq_stall, eq_data      coef_a, coef_b, coef_c (Q8.8)
//   sol       sol_valid, sol_stall, sol_data   root (Q16.16), status, saturated
//
// One equation per cycle while eq_stall is low. The square root resolves one bit
// per stage and the divider one quotient bit per stage. Reset clears every valid
// bit; data registers are not reset.
// A stalled result parks the next one in a skid register; eq_stall is the
// skid-full flag, and the whole pipeline holds while it is set.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module quadratic_smaller_root
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          eq_valid,
    output logic               eq_stall,
    input  wire qsr_pkg::eq_t  eq_data,
    output logic               sol_valid,
    input  wire logic          sol_stall,
    output qsr_pkg::sol_t      sol_data
);
    import qsr_pkg::*;

    logic en;

    // stage 1: products
    logic                           v1_reg;
    logic signed [COEF_WIDTH-1:0]   a1_reg;
    logic signed [COEF_WIDTH-1:0]   b1_reg;
    logic signed [2*COEF_WIDTH-1:0] bb1_reg;
    logic signed [2*COEF_WIDTH-1:0] ac1_reg;
    logic signed [2*COEF_WIDTH-1:0] bb1_next;
    logic signed [2*COEF_WIDTH-1:0] ac1_next;

    // stage 2: discriminant
    logic              v2_reg;
    logic [RAD_W-1:0]  rad2_reg;
    sq_side_t          side2_reg;
    logic signed [DISC_W-1:0] disc;
    logic [RAD_W-1:0]  rad2_next;
    sq_side_t          side2_next;

    // square root
    logic            sq_vld;
    logic [SQ_W-1:0] sq_root;
    sq_side_t        sq_side;

    // stage 3: numerator and denominator magnitudes
    logic                    v3_reg;
    logic [NUM_W-1:0]        nmag3_reg;
    logic [NUM_W-1:0]        dmag3_reg;
    div_side_t               side3_reg;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
    logic [NUM_W-1:0]        nmag3_next;
    logic [NUM_W-1:0]        dmag3_next;
    div_side_t               side3_next;

    // divider
    logic              dv_vld;
    logic [DIVD_W-1:0] dv_quot;
    div_side_t         dv_side;

    // tail: sign, saturation, status
    logic                  tail_valid_reg;
    sol_t                  tail_reg;
    sol_t                  tail_next;
    logic [EXT_W-1:0]      qext;
    logic [ROOT_WIDTH-1:0] qlow;
    logic                  pos_ov;
    logic                  neg_ov;

    // output register and skid
    logic out_valid_reg;
    sol_t out_reg;
    logic skid_valid_reg;
    sol_t skid_reg;
    logic out_free;

    assign en       = !skid_valid_reg;
    assign eq_stall = skid_valid_reg;

    assign bb1_next = eq_data.coef_b * eq_data.coef_b;
    assign ac1_next = eq_data.coef_a * eq_data.coef_c;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= eq_data.coef_a;
            b1_reg  <= eq_data.coef_b;
            bb1_reg <= bb1_next;
            ac1_reg <= ac1_next;
        end
    end

    assign disc = DISC_W'(bb1_reg) - (DISC_W'(ac1_reg) <<< 2);

    always_comb
    begin
        side2_next.a = a1_reg;
        side2_next.b = b1_reg;
        if (a1_reg == '0)
            side2_next.status = ST_A_ZERO;
        else if (disc < 0)
            side2_next.status = ST_COMPLEX;
        else
            side2_next.status = ST_REAL;
        rad2_next = disc[DISC_W-1] ? '0 : RAD_W'(disc);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad2_reg  <= rad2_next;
            side2_reg <= side2_next;
        end
    end

    qsr_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v2_reg),
        .rad      (rad2_reg),
        .side_in  (side2_reg),
        .out_vld  (sq_vld),
        .sq_root  (sq_root),
        .side_out (sq_side)
    );

    assign num = -NUM_W'(sq_side.b) - $signed({1'b0, sq_root});
    assign den = NUM_W'(sq_side.a) <<< 1;

    always_comb
    begin
        nmag3_next        = num[NUM_W-1] ? -num : num;
        dmag3_next        = den[NUM_W-1] ? -den : den;
        side3_next.neg    = num[NUM_W-1] ^ sq_side.a[COEF_WIDTH-1];
        side3_next.status = sq_side.status;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag3_reg <= nmag3_next;
            dmag3_reg <= dmag3_next;
            side3_reg <= side3_next;
        end
    end

    qsr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v3_reg),
        .dividend ({nmag3_reg, (2 * FRAC_BITS)'(0)}),
        .divisor  (dmag3_reg),
        .side_in  (side3_reg),
        .out_vld  (dv_vld),
        .quotient (dv_quot),
        .side_out (dv_side)
    );

    assign qext   = EXT_W'(dv_quot);
    assign qlow   = qext[ROOT_WIDTH-1:0];
    assign pos_ov = !dv_side.neg && (qext > EXT_W'({1'b0, {(ROOT_WIDTH-1){1'b1}}}));
    assign neg_ov = dv_side.neg && (qext > EXT_W'({1'b1, {(ROOT_WIDTH-1){1'b0}}}));

    always_comb
    begin
        tail_next.status    = dv_side.status;
        tail_next.saturated = 1'b0;
        tail_next.root      = '0;
        if (dv_side.status == ST_REAL)
        begin
            if (pos_ov)
            begin
                tail_next.root      = {1'b0, {(ROOT_WIDTH-1){1'b1}}};
                tail_next.saturated = 1'b1;
            end
            else if (neg_ov)
            begin
                tail_next.root      = {1'b1, {(ROOT_WIDTH-1){1'b0}}};
                tail_next.saturated = 1'b1;
            end
            else
            begin
                tail_next.root = dv_side.neg ? -qlow : qlow;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg         <= eq_valid;
            v2_reg         <= v1_reg;
            v3_reg         <= sq_vld;
            tail_valid_reg <= dv_vld;
        end
    end

    // tail leaves on every enabled cycle: to the output, or to the skid
    assign out_free = !out_valid_reg || !sol_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= tail_valid_reg;
            end
        end
        else if (en && tail_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : tail_reg;
        end
        else if (en && tail_valid_reg)
        begin
            skid_reg <= tail_reg;
        end
    end

    assign sol_valid = out_valid_reg;
    assign sol_data  = out_reg;

    `QSR_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg)
    `QSR_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_reg) |-> $past(out_valid_reg && sol_stall))
    `QSR_ASSERT(a_special_root_zero,
        (out_valid_reg && out_reg.status != ST_REAL) |-> (out_reg.root == '0 && !out_reg.saturated))
    `QSR_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> (!out_valid_reg && !skid_valid_reg))

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives Q8.8 quadratic equations into quadratic_smaller_root and checks each
// smaller root, status and saturation flag against a bit-exact predictor, or
// against the result typed into the table. A directed table covers a-zero,
// complex and extreme coefficients. Random equations follow, with bursty input,
// patterned output stall and one long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qsr_pkg::*;

    localparam int RANDOM_EQS  = 1330;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 80;

    typedef struct {
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [COEF_WIDTH-1:0] b;
        logic signed [COEF_WIDTH-1:0] c;
        bit                           typed;
        sol_t                         sol;
    } eq_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic eq_valid = 1'b0;
    logic eq_stall;
    eq_t  eq_data = '0;
    logic sol_valid;
    logic sol_stall = 1'b0;
    sol_t sol_data;

    sol_t    pending_roots[$];
    eq_row_t eq_table[$];
    int      errors = 0;
    int      cycles = 0;
    int      sent = 0;

    quadratic_smaller_root dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .eq_valid (eq_valid),
        .eq_stall (eq_stall),
        .eq_data  (eq_data),
        .sol_valid(sol_valid),
        .sol_stall(sol_stall),
        .sol_data (sol_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quadratic_smaller_root test failed");
            $finish;
        end
    end

    // floor of the square root, one result bit at a time
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitv;
        rem  = v;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic sol_t smaller_root(eq_t eq);
        longint a;
        longint b;
        longint c;
        longint disc;
        longint num;
        longint q;
        sol_t   r;
        a = longint'(eq.coef_a);
        b = longint'(eq.coef_b);
        c = longint'(eq.coef_c);
        r = '0;
        if (a == 0)
            r.status = ST_A_ZERO;
        else
        begin
            disc = b * b - 4 * a * c;
            if (disc < 0)
                r.status = ST_COMPLEX;
            else
            begin
                num = -b - longint'(floor_sqrt(disc));
                q = (num * (64'sd1 <<< (2 * FRAC_BITS))) / (2 * a);
                r.status = ST_REAL;
                if (q > 64'sd2147483647)
                begin
                    q = 64'sd2147483647;
                    r.saturated = 1'b1;
                end
                else if (q < -64'sd2147483648)
                begin
                    q = -64'sd2147483648;
                    r.saturated = 1'b1;
                end
                r.root = q[31:0];
            end
        end
        return r;
    endfunction

    task automatic add_row(int a, int b, int c, int typed, sol_t sol);
        eq_row_t row;
        row.a = COEF_WIDTH'(a);
        row.b = COEF_WIDTH'(b);
        row.c = COEF_WIDTH'(c);
        row.typed = (typed != 0);
        row.sol = sol;
        eq_table.push_back(row);
    endtask

    function automatic sol_t make_sol(int root, logic [1:0] status);
        sol_t s;
        s.root = root;
        s.status = status;
        s.saturated = 1'b0;
        return s;
    endfunction

    // offer one equation and hold it until the transfer happens
    task automatic send_eq(eq_row_t row);
        eq_t eq;
        int  gap;
        eq.coef_a = row.a;
        eq.coef_b = row.b;
        eq.coef_c = row.c;
        eq_valid <= 1'b1;
        eq_data  <= eq;
        do
            @(posedge clk);
        while (!(eq_valid && !eq_stall));
        pending_roots.push_back(row.typed ? row.sol : smaller_root(eq));
        sent++;
        // end a burst now and then
        if ($urandom_range(0, 9) < 2)
        begin
            gap = $urandom_range(1, 6);
            eq_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int pick_coef();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1: return int'($urandom_range(0, 512)) - 256;
            2: return int'($urandom_range(0, 8)) - 4;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    initial
    begin
        eq_row_t row;
        rst_n <= 1'b0;
        add_row(0, 0, 0, 1, make_sol(0, ST_A_ZERO));
        add_row(0, 32767, -32768, 1, make_sol(0, ST_A_ZERO));
        add_row(0, -32768, 32767, 1, make_sol(0, ST_A_ZERO));
        add_row(256, 0, 256, 1, make_sol(0, ST_COMPLEX));
        add_row(32767, 0, 32767, 1, make_sol(0, ST_COMPLEX));
        add_row(-32768, 0, -32768, 1, make_sol(0, ST_COMPLEX));
        add_row(256, 0, -256, 1, make_sol(-65536, ST_REAL));
        add_row(1, 32767, -32768, 1, make_sol(-2147483648, ST_REAL));
        add_row(256, 0, 0, 1, make_sol(0, ST_REAL));
        add_row(1, 32767, 0, 0, '0);
        add_row(-1, 32767, 32767, 0, '0);
        add_row(-1, -32768, 32767, 0, '0);
        add_row(-32768, -32768, -32768, 0, '0);
        add_row(32767, 32767, 32767, 0, '0);
        add_row(-32768, 32767, 32767, 0, '0);
        add_row(32767, -32768, -32768, 0, '0);
        add_row(-1, -1, -1, 0, '0);
        add_row(256, -768, 512, 0, '0);
        add_row(-256, 512, 768, 0, '0);
        add_row(1, -32768, 0, 0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (eq_table[i])
            send_eq(eq_table[i]);
        for (int n = 0; n < RANDOM_EQS; n++)
        begin
            row.a = COEF_WIDTH'(pick_coef());
            row.b = COEF_WIDTH'(pick_coef());
            row.c = COEF_WIDTH'(pick_coef());
            row.typed = 1'b0;
            row.sol = '0;
            send_eq(row);
        end
        eq_valid <= 1'b0;

        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("quadratic_smaller_root test passed");
        else
            $display("quadratic_smaller_root test failed");
        $finish;
    end

    // output stall: runs of free flow, light and heavy stall, one long hold-off
    initial
    begin
        int mode;
        bit held = 0;
        forever
        begin
            if (!held && sent > 300)
            begin
                held = 1;
                sol_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(8, 64))
            begin
                case (mode)
                    0: sol_stall <= 1'b0;
                    1: sol_stall <= ($urandom_range(0, 9) < 3);
                    default: sol_stall <= ($urandom_range(0, 9) < 8);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        sol_t want;
        if (rst_n && sol_valid && !sol_stall)
        begin
            if (pending_roots.size() == 0)
            begin
                $error("unexpected result root=%0d status=%0d", sol_data.root,
                       sol_data.status);
                errors++;
            end
            else
            begin
                want = pending_roots.pop_front();
                if (sol_data.root !== want.root)
                begin
                    $error("root: expected %0d, got %0d", want.root, sol_data.root);
                    errors++;
                end
                if (sol_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status,
                           sol_data.status);
                    errors++;
                end
                if (sol_data.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0d, got %0d", want.saturated,
                           sol_data.saturated);
                    errors++;
                end
            end
        end
    end
endmodule
`default_nettype wire
